### rtl/core/ssd_pkg.sv
// Shared types, codes and decode functions for the seven-segment scan driver.
package ssd_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_MS   = 2'd1;
  localparam logic [1:0] KIND_RAW  = 2'd2;

  localparam int unsigned LOAD_DIGITS = 4;
  localparam logic [7:0]  DWELL_RESET = 8'd2;

  localparam logic signed [15:0] MS_MAX_S = 16'sd9999;
  localparam logic [13:0]        MS_MAX   = 14'd9999;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD,
    OP_IDLE
  } op_t;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    op_t                         op;
    logic [LOAD_DIGITS-1:0][3:0] digits;
    logic [LOAD_DIGITS-1:0]      dots;
    logic [15:0]                 hold;
  } cmd_t;

  typedef struct packed {
    op_t                         op;
    logic                        is_ms;
    logic [LOAD_DIGITS-1:0][3:0] digits;
    logic [9:0]                  rem;
    logic [LOAD_DIGITS-1:0]      dots;
    logic [15:0]                 hold;
  } stage_t;

  function automatic digit_t clamp_digit(logic signed [7:0] v);
    digit_t d;
    if (v < 8'sd0) begin
      d = 4'd0;
    end else if (v > 8'sd9) begin
      d = 4'd9;
    end else begin
      d = v[3:0];
    end
    return d;
  endfunction

  function automatic logic [6:0] seg_map(digit_t d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/ssd_in_if.sv
// Input word channel of the seven-segment scan driver.
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] ms_value;
  logic signed [7:0]  digit_zero;
  logic signed [7:0]  digit_one;
  logic signed [7:0]  digit_two;
  logic signed [7:0]  digit_three;
  logic [3:0]         dot_mask;
  logic [15:0]        hold_ticks;

  modport source (
    output valid, kind, ms_value, digit_zero, digit_one, digit_two, digit_three,
           dot_mask, hold_ticks,
    input  ready
  );
  modport sink (
    input  valid, kind, ms_value, digit_zero, digit_one, digit_two, digit_three,
           dot_mask, hold_ticks,
    output ready
  );
endinterface

### rtl/core/ssd_out_if.sv
// Result word channel carrying the display pin drive.
interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [3:0] digit_enable;
  logic       busy_res;

  modport source (
    output valid, segments, digit_enable, busy_res,
    input  ready
  );
  modport sink (
    input  valid, segments, digit_enable, busy_res,
    output ready
  );
endinterface

### rtl/core/ssd_cfg_if.sv
// Configuration write channel for the dwell register.
interface ssd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] dwell_ticks;

  modport source (
    output valid, dwell_ticks,
    input  ready
  );
  modport sink (
    input  valid, dwell_ticks,
    output ready
  );
endinterface

### rtl/core/ssd_front.sv
// Front end: accepts words, clamps and splits load values into digits.
module ssd_front (
  input  logic             clk,
  input  logic             rst_n,
  ssd_in_if.sink           in_ch,
  output logic             push_valid,
  output ssd_pkg::cmd_t    push_cmd,
  input  logic             push_ready
);

  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam logic [15:0] RECIP_100  = 16'd41;
  localparam logic [13:0] RECIP_10   = 14'd103;

  ssd_pkg::stage_t a_r;
  ssd_pkg::stage_t a_nxt;
  logic            a_valid_r;
  logic            a_ready;

  logic [13:0] ms_u;
  logic [27:0] prod_k;
  logic [3:0]  thou;
  logic [13:0] thou_x;

  logic [15:0] prod_h;
  logic [3:0]  hund;
  logic [9:0]  hund_x;
  logic [6:0]  rem2;
  logic [13:0] prod_t;
  logic [3:0]  tens;
  logic [6:0]  tens_x;
  logic [3:0]  units;

  assign a_ready     = !a_valid_r || push_ready;
  assign in_ch.ready = a_ready;

  always_comb begin
    if (in_ch.ms_value < 16'sd0) begin
      ms_u = 14'd0;
    end else if (in_ch.ms_value > ssd_pkg::MS_MAX_S) begin
      ms_u = ssd_pkg::MS_MAX;
    end else begin
      ms_u = in_ch.ms_value[13:0];
    end
    prod_k = 28'(ms_u) * 28'(RECIP_1000);
    thou   = prod_k[26:23];
    thou_x = 14'(thou) * 14'd1000;

    a_nxt.hold  = in_ch.hold_ticks;
    a_nxt.rem   = 10'(ms_u - thou_x);
    a_nxt.is_ms = 1'b0;
    case (in_ch.kind)
      ssd_pkg::KIND_TICK: begin
        a_nxt.op = ssd_pkg::OP_TICK;
      end
      ssd_pkg::KIND_MS: begin
        a_nxt.op    = ssd_pkg::OP_LOAD;
        a_nxt.is_ms = 1'b1;
      end
      ssd_pkg::KIND_RAW: begin
        a_nxt.op = ssd_pkg::OP_LOAD;
      end
      default: begin
        a_nxt.op = ssd_pkg::OP_IDLE;
      end
    endcase
    if (a_nxt.is_ms) begin
      a_nxt.digits = {4'd0, 4'd0, 4'd0, thou};
      a_nxt.dots   = 4'b0001;
    end else begin
      a_nxt.digits = {ssd_pkg::clamp_digit(in_ch.digit_three),
                      ssd_pkg::clamp_digit(in_ch.digit_two),
                      ssd_pkg::clamp_digit(in_ch.digit_one),
                      ssd_pkg::clamp_digit(in_ch.digit_zero)};
      a_nxt.dots   = in_ch.dot_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) begin
      a_r <= a_nxt;
    end
  end

  always_comb begin
    prod_h = 16'(a_r.rem) * RECIP_100;
    hund   = prod_h[15:12];
    hund_x = 10'(hund) * 10'd100;
    rem2   = 7'(a_r.rem - hund_x);
    prod_t = 14'(rem2) * RECIP_10;
    tens   = prod_t[13:10];
    tens_x = 7'(tens) * 7'd10;
    units  = 4'(rem2 - tens_x);

    push_cmd.op   = a_r.op;
    push_cmd.hold = a_r.hold;
    push_cmd.dots = a_r.dots;
    if (a_r.is_ms) begin
      push_cmd.digits = {units, tens, hund, a_r.digits[0]};
    end else begin
      push_cmd.digits = a_r.digits;
    end
  end

  assign push_valid = a_valid_r;

endmodule

### rtl/core/ssd_queue.sv
// Short command queue between the front end and the scan engine.
module ssd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  ssd_pkg::cmd_t    push_cmd,
  output logic             push_ready,
  output logic             pop_valid,
  output ssd_pkg::cmd_t    pop_cmd,
  input  logic             pop_ready
);

  localparam int unsigned CNT_W = $clog2(ssd_pkg::QUEUE_DEPTH + 1);

  ssd_pkg::cmd_t                mem_r [ssd_pkg::QUEUE_DEPTH];
  logic [ssd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [ssd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]             count_r;
  logic                         push;
  logic                         pop;

  assign push_ready = count_r != CNT_W'(ssd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/ssd_back.sv
// Scan engine: display state, dwell and hold counting, pin drive register.
module ssd_back #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       dwell,
  input  logic             pop_valid,
  input  ssd_pkg::cmd_t    pop_cmd,
  output logic             pop_ready,
  ssd_out_if.source        out_ch
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [ssd_pkg::LOAD_DIGITS-1:0][3:0] digits_r, digits_nxt;
  logic [ssd_pkg::LOAD_DIGITS-1:0]      dots_r, dots_nxt;
  logic [POS_W-1:0]                     pos_r, pos_nxt;
  logic [7:0]                           dwell_cnt_r, dwell_cnt_nxt;
  logic [15:0]                          hold_r, hold_nxt;
  logic                                 active_r, active_nxt;

  logic       out_valid_r;
  logic [7:0] seg_r, seg_nxt;
  logic [3:0] en_r, en_nxt;
  logic       busy_r;

  logic       fire;
  logic [7:0] dwell_eff;
  logic [2:0] pos_w;
  logic [3:0] cur_digit;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign fire      = pop_valid && pop_ready;
  assign dwell_eff = (dwell == 8'd0) ? 8'd1 : dwell;

  always_comb begin
    digits_nxt    = digits_r;
    dots_nxt      = dots_r;
    pos_nxt       = pos_r;
    dwell_cnt_nxt = dwell_cnt_r;
    hold_nxt      = hold_r;
    active_nxt    = active_r;
    case (pop_cmd.op)
      ssd_pkg::OP_LOAD: begin
        digits_nxt    = pop_cmd.digits;
        dots_nxt      = pop_cmd.dots;
        hold_nxt      = pop_cmd.hold;
        pos_nxt       = '0;
        dwell_cnt_nxt = 8'd0;
        active_nxt    = pop_cmd.hold != 16'd0;
      end
      ssd_pkg::OP_TICK: begin
        if (active_r) begin
          if (hold_r != 16'd0) begin
            hold_nxt = hold_r - 16'd1;
          end
          if ({1'b0, dwell_cnt_r} + 9'd1 >= {1'b0, dwell_eff}) begin
            dwell_cnt_nxt = 8'd0;
            if ({1'b0, pos_r} + (POS_W+1)'(1) >= (POS_W+1)'(DIGIT_COUNT)) begin
              pos_nxt = '0;
              if (hold_nxt == 16'd0) begin
                active_nxt = 1'b0;
              end
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end else begin
            dwell_cnt_nxt = dwell_cnt_r + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pos_w     = 3'(pos_nxt);
    cur_digit = pos_w[2] ? 4'd0 : digits_nxt[pos_w[1:0]];
    seg_nxt   = 8'd0;
    en_nxt    = 4'd0;
    if (active_nxt) begin
      seg_nxt = {!pos_w[2] && dots_nxt[pos_w[1:0]], ssd_pkg::seg_map(cur_digit)};
      en_nxt  = pos_w[2] ? 4'd0 : (4'd1 << pos_w[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r    <= '0;
      dots_r      <= '0;
      pos_r       <= '0;
      dwell_cnt_r <= '0;
      hold_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_ready) begin
        out_valid_r <= pop_valid;
      end
      if (fire) begin
        digits_r    <= digits_nxt;
        dots_r      <= dots_nxt;
        pos_r       <= pos_nxt;
        dwell_cnt_r <= dwell_cnt_nxt;
        hold_r      <= hold_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seg_r  <= seg_nxt;
      en_r   <= en_nxt;
      busy_r <= active_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.digit_enable = en_r;
  assign out_ch.busy_res     = busy_r;

endmodule

### rtl/core/seven_segment_scan_driver.sv
// Seven-segment scan driver top level: front end, queue, scan engine, dwell register.
// A word passes the front stage register, the queue and the output register before its pin drive is offered.
// Throughput: one word per cycle; the front stage, two-entry queue and output register
// keep input and output stalls apart, so the only limit is the consumer's ready.
// Reset: display dark, all digits and points zero, dwell 2, queue and pipeline empty.
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_ch,
  ssd_out_if.source  out_ch,
  ssd_cfg_if.sink    cfg_ch
);

  logic          dwell_r;
  logic [7:0]    dwell_val_r;
  logic          push_valid;
  ssd_pkg::cmd_t push_cmd;
  logic          push_ready;
  logic          pop_valid;
  ssd_pkg::cmd_t pop_cmd;
  logic          pop_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_val_r <= ssd_pkg::DWELL_RESET;
      dwell_r     <= 1'b0;
    end else begin
      dwell_r <= cfg_ch.valid;
      if (cfg_ch.valid) begin
        dwell_val_r <= cfg_ch.dwell_ticks;
      end
    end
  end

  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  ssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  ssd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dwell     (dwell_val_r),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot0(out_ch.digit_enable))
    else $error("digit enable not one-hot");

  a_dark_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.busy_res) |-> (out_ch.segments == 8'd0 &&
                                            out_ch.digit_enable == 4'd0))
    else $error("pins driven while display is dark");

  a_dwell_write: assert property (@(posedge clk) disable iff (!rst_n)
    dwell_r |-> dwell_val_r == $past(cfg_ch.dwell_ticks))
    else $error("dwell register did not take written word");

  a_queue_on_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && !out_ch.valid) |-> pop_ready)
    else $error("scan engine stalled with empty output register");

endmodule
